// File: design/midpoint_line_rasterizer_top_macros.svh
// Assertion macros shared by the rasterizer checker.
// Needs nothing else; included by the checker file.
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, clocked on rising edge, disabled in reset
`define MLR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; imported by the top level and its checker.
package mlr_pkg;

	localparam int COORD_W           = 6;   // width of every coordinate field
	localparam int COORD_RANGE_DEF   = 64;
	localparam int IN_TDATA_W        = 24;  // four coordinates, no padding
	localparam int OUT_TDATA_W       = 16;  // two coordinates plus zero pad
	localparam int OUT_PAD_W         = OUT_TDATA_W - 2 * COORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SETUP,
		ST_WALK
	} mlr_state_t;

endpackage

// File: design/midpoint_line_rasterizer_top.sv
// Midpoint line rasterizer: one line request in, one beat per pixel out.
// Depends on mlr_pkg.
//
//  channel  | dir | tdata fields (low bit up)                 | tlast
//  s_axis   | in  | start_x, start_y, end_x, end_y (24 bits)  | -
//  m_axis   | out | point_x, point_y, 4 zero bits (16 bits)   | last_point
//
// A request passes the setup states ST_DELTA (deltas and axis choice) and
// ST_SETUP (swap and decision variable init), then walks |major delta| + 1 pixels.
// The walk advances only when the output register is free or being drained, so a
// stalled m_axis stretches it beat for beat. s_axis_tready is high only when idle,
// so a new request is taken only after the previous line's last pixel is loaded.
// arst_n clears the sequencer and the output valid flag.
module midpoint_line_rasterizer_top
	import mlr_pkg::*;
#(
	parameter int COORD_RANGE = COORD_RANGE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // point_x, point_y, zero pad
	output logic                   m_axis_tlast    // last_point
);

	localparam int CW = (COORD_RANGE > 1) ? $clog2(COORD_RANGE) : 1;
	localparam int EW = CW + 3;
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_RANGE - 1);

	mlr_state_t state_q, state_d;

	logic [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic          xmaj_q;
	logic [CW-1:0] maja_q, mina_q, majb_q, minb_q;
	logic [CW-1:0] maj_q, end_q, mn_q;
	logic          dir_up_q;
	logic signed [EW-1:0] e_q;
	logic [CW:0]   inc_q, dec_q;

	logic [COORD_W-1:0] px_q, py_q;
	logic               last_q, out_valid_q;

	logic out_free, out_load, walk_last;

	function automatic logic [CW-1:0] clamp(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] c;
		c = (v > COORD_MAX) ? COORD_MAX : v;
		return c[CW-1:0];
	endfunction

	// setup stage one: deltas and axis choice
	logic [CW-1:0] adx, ady;
	logic          x_major;
	assign adx     = (ax_q > bx_q) ? ax_q - bx_q : bx_q - ax_q;
	assign ady     = (ay_q > by_q) ? ay_q - by_q : by_q - ay_q;
	assign x_major = adx >= ady;

	// setup stage two: order endpoints along the major axis
	logic          swap;
	logic [CW-1:0] m0, m1, n0, n1, big, small_d;
	logic signed [EW-1:0] e_init;
	assign swap    = maja_q > majb_q;
	assign m0      = swap ? majb_q : maja_q;
	assign m1      = swap ? maja_q : majb_q;
	assign n0      = swap ? minb_q : mina_q;
	assign n1      = swap ? mina_q : minb_q;
	assign big     = m1 - m0;
	assign small_d = (n1 > n0) ? n1 - n0 : n0 - n1;
	assign e_init  = $signed(EW'(big)) - $signed(EW'({small_d, 1'b0}));

	assign out_free  = !out_valid_q || m_axis_tready;
	assign walk_last = maj_q == end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_WALK;
			ST_WALK: begin
				out_load = out_free;
				if (out_free && walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath: one add or subtract on the decision variable per pixel
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ax_q <= clamp(s_axis_tdata[COORD_W-1:0]);
			ay_q <= clamp(s_axis_tdata[2*COORD_W-1:COORD_W]);
			bx_q <= clamp(s_axis_tdata[3*COORD_W-1:2*COORD_W]);
			by_q <= clamp(s_axis_tdata[4*COORD_W-1:3*COORD_W]);
		end
		if (state_q == ST_DELTA) begin
			xmaj_q <= x_major;
			maja_q <= x_major ? ax_q : ay_q;
			mina_q <= x_major ? ay_q : ax_q;
			majb_q <= x_major ? bx_q : by_q;
			minb_q <= x_major ? by_q : bx_q;
		end
		if (state_q == ST_SETUP) begin
			maj_q    <= m0;
			end_q    <= m1;
			mn_q     <= n0;
			dir_up_q <= n1 > n0;
			e_q      <= e_init;
			inc_q    <= {big - small_d, 1'b0};
			dec_q    <= {small_d, 1'b0};
		end
		if (out_load) begin
			px_q   <= COORD_W'(xmaj_q ? maj_q : mn_q);
			py_q   <= COORD_W'(xmaj_q ? mn_q : maj_q);
			last_q <= walk_last;
			maj_q  <= maj_q + 1'b1;
			if (e_q < 0) begin
				mn_q <= dir_up_q ? mn_q + 1'b1 : mn_q - 1'b1;
				e_q  <= e_q + $signed(EW'(inc_q));
			end else begin
				e_q  <= e_q - $signed(EW'(dec_q));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, py_q, px_q};
	assign m_axis_tlast  = last_q;

endmodule

// File: design/mlr_checker.sv
// Port-level checker for the midpoint line rasterizer, bound to the top level.
// Depends on mlr_pkg and midpoint_line_rasterizer_top_macros.svh.
`include "midpoint_line_rasterizer_top_macros.svh"

module mlr_checker
	import mlr_pkg::*;
#(
	parameter int COORD_RANGE = COORD_RANGE_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,   // point_x, point_y, zero pad
	input logic                   m_axis_tlast    // last_point
);

	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(COORD_RANGE - 1);

	// a stalled output beat holds
	`MLR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

	// a request is never taken while a line is still being drawn
	`MLR_ASSERT_NOW(a_busy_walk, clk, arst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready mid-line")

	// an accepted request drops input ready in the following cycle
	`MLR_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

	// pixels stay inside the tile
	`MLR_ASSERT_NOW(a_in_tile, clk, arst_n, m_axis_tvalid, (m_axis_tdata[COORD_W-1:0] <= COORD_MAX) && (m_axis_tdata[2*COORD_W-1:COORD_W] <= COORD_MAX), "pixel outside tile")

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(
	.COORD_RANGE(COORD_RANGE)
) u_mlr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/midpoint_line_rasterizer_top_tb.sv
// Self-checking testbench for the midpoint line rasterizer: drives line
// requests on s_axis, predicts every pixel and checks each m_axis beat.
// Depends on mlr_pkg and midpoint_line_rasterizer_top.
`timescale 1ns / 1ps

module midpoint_line_rasterizer_top_tb;
	import mlr_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} pixel_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // start_x, start_y, end_x, end_y
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // point_x, point_y, zero pad
	logic                   m_axis_tlast;        // last_point

	pixel_t      exp_pixels[$];
	int unsigned lines_sent = 0;
	int unsigned pixels_seen = 0;
	int unsigned errors = 0;

	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int unsigned rx_hold_req = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_gap_left = 0;

	midpoint_line_rasterizer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(15, 40);
	endfunction

	// Walk the line along its major axis with the integer midpoint error term.
	// Coordinates are 6 bits, so nothing ever exceeds the tile edge here.
	function automatic void trace_line(input logic [COORD_W-1:0] sx, sy, ex, ey);
		int     ax, ay, bx, by, adx, ady;
		int     maj0, maj1, min0, min1, tmp;
		int     span, rise, dir, err, mn, maj;
		bit     x_major;
		pixel_t px;
		ax = int'(sx);
		ay = int'(sy);
		bx = int'(ex);
		by = int'(ey);
		adx = (ax > bx) ? ax - bx : bx - ax;
		ady = (ay > by) ? ay - by : by - ay;
		x_major = (adx >= ady);
		if (x_major) begin
			maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
		end else begin
			maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
		end
		// start from the smaller major coordinate; tie keeps the first endpoint
		if (maj0 > maj1) begin
			tmp = maj0; maj0 = maj1; maj1 = tmp;
			tmp = min0; min0 = min1; min1 = tmp;
		end
		span = maj1 - maj0;
		rise = (min1 > min0) ? min1 - min0 : min0 - min1;
		dir = (min1 > min0) ? 1 : -1;
		err = span - 2 * rise;
		mn = min0;
		for (maj = maj0; maj <= maj1; maj++) begin
			px.x = x_major ? maj[COORD_W-1:0] : mn[COORD_W-1:0];
			px.y = x_major ? mn[COORD_W-1:0] : maj[COORD_W-1:0];
			px.last = (maj == maj1);
			exp_pixels.insert(exp_pixels.size(), px);
			if (err < 0) begin
				mn += dir;
				err += 2 * (span - rise);
			end else begin
				err -= 2 * rise;
			end
		end
	endfunction

	// output ready: random gaps, plus a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else if (rx_gap_left != 0) begin
			m_axis_tready <= 1'b0;
			rx_gap_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_idle_en)
				rx_gap_left = pick_gap();
		end
	end

	// pixel checker: every accepted beat against the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pixels_seen++;
			if (exp_pixels.size() == 0) begin
				errors++;
				if (errors < 40)
					$display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
						m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W],
						m_axis_tlast);
			end else begin
				want = exp_pixels.pop_front();
				if (m_axis_tdata[COORD_W-1:0] !== want.x) begin
					errors++;
					if (errors < 40)
						$display("%0t: point_x expected %0d actual %0d", $time, want.x,
							m_axis_tdata[COORD_W-1:0]);
				end
				if (m_axis_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
					errors++;
					if (errors < 40)
						$display("%0t: point_y expected %0d actual %0d", $time, want.y,
							m_axis_tdata[2*COORD_W-1:COORD_W]);
				end
				if (m_axis_tdata[OUT_TDATA_W-1:2*COORD_W] !== '0) begin
					errors++;
					if (errors < 40)
						$display("%0t: pad bits expected 0 actual %0h", $time,
							m_axis_tdata[OUT_TDATA_W-1:2*COORD_W]);
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					if (errors < 40)
						$display("%0t: last_point expected %0b actual %0b", $time,
							want.last, m_axis_tlast);
				end
			end
		end
	end

	// offer one request beat and predict its pixels once it is taken
	task automatic send_line(input logic [COORD_W-1:0] sx, sy, ex, ey);
		int unsigned gap;
		gap = tx_idle_en ? pick_gap() : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ey, ex, sy, sx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		trace_line(sx, sy, ex, ey);
		lines_sent++;
	endtask

	// drop valid and let every predicted pixel come out
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (exp_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		send_line(0, 0, 0, 0);        // equal endpoints
		send_line(63, 63, 63, 63);
		send_line(0, 0, 63, 0);       // full horizontal
		send_line(63, 0, 0, 0);       // horizontal, reversed
		send_line(0, 0, 0, 63);       // full vertical
		send_line(5, 63, 5, 0);       // vertical, reversed
		send_line(0, 0, 63, 63);      // diagonal, |dx| == |dy| goes x-major
		send_line(63, 0, 0, 63);
		send_line(0, 63, 63, 0);
		send_line(0, 0, 2, 1);        // error term hits zero
		send_line(2, 1, 0, 0);
		send_line(0, 0, 1, 2);
		send_line(10, 10, 40, 20);
		send_line(40, 20, 10, 10);
		send_line(10, 10, 20, 50);    // steep
		send_line(20, 50, 10, 10);
		send_line(0, 63, 63, 62);     // shallow, minor steps down
		send_line(30, 30, 31, 31);
		send_line(30, 30, 31, 30);
		send_line(62, 1, 63, 0);
		send_line(63, 63, 0, 0);
		send_line(21, 42, 42, 21);
		wait_drained();
	endtask

	// output held off while requests keep coming: block stalls its input
	task automatic test_output_holdoff();
		tx_idle_en = 1'b0;
		rx_hold_req = 300;
		send_line(0, 5, 63, 40);
		send_line(7, 0, 50, 63);
		send_line(63, 10, 20, 30);
		rx_hold_req = 200;
		send_line(1, 1, 62, 2);
		send_line(33, 63, 33, 0);
		send_line(12, 9, 12, 9);
		tx_idle_en = 1'b1;
		wait_drained();
	endtask

	// sender pauses for a full drain between small bursts
	task automatic test_drain_pause();
		send_line(3, 4, 9, 1);
		send_line(60, 2, 55, 8);
		wait_drained();
		send_line(17, 17, 17, 18);
		send_line(44, 0, 0, 44);
		wait_drained();
		send_line(8, 50, 9, 60);
		send_line(63, 0, 63, 1);
		wait_drained();
	endtask

	task automatic test_random_lines(input int unsigned count, input bit tx_en, rx_en);
		int unsigned r, d;
		int          sx, sy, ex, ey, t;
		tx_idle_en = tx_en;
		rx_idle_en = rx_en;
		repeat (count) begin
			r = $urandom_range(0, 99);
			sx = $urandom_range(0, 63);
			sy = $urandom_range(0, 63);
			ex = $urandom_range(0, 63);
			ey = $urandom_range(0, 63);
			if (r < 50) begin
				// short lines keep the run quick
				ex = sx + $urandom_range(0, 14) - 7;
				ey = sy + $urandom_range(0, 14) - 7;
				ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
				ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
			end else if (r < 75) begin
				// fully random endpoints
			end else if (r < 85) begin
				if ($urandom_range(0, 1))
					ey = sy;
				else
					ex = sx;
			end else if (r < 95) begin
				d = (sx > ex) ? sx - ex : ex - sx;
				t = $urandom_range(0, 63 - d);
				if ($urandom_range(0, 1)) begin
					sy = t;
					ey = t + d;
				end else begin
					sy = t + d;
					ey = t;
				end
			end else begin
				ex = sx;
				ey = sy;
			end
			send_line(COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey));
		end
		wait_drained();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_output_holdoff();
		test_drain_pause();
		test_random_lines(140, 1'b1, 1'b1);
		test_random_lines(40, 1'b0, 1'b0);
		test_random_lines(55, 1'b1, 1'b1);
		repeat (16) @(posedge clk);
		$display("Drew %0d lines, %0d pixels checked, %0d errors.", lines_sent,
			pixels_seen, errors);
		$display("Covered point, axis, diagonal and full-tile lines, output hold-off, drains.");
		if (errors == 0 && exp_pixels.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
